// ----- rtl/core/relative_quaternion_to_euler_assert.svh -----
// Assertion macros for the relative quaternion to Euler block.
// Used by the top level only; no other dependencies.
`ifndef RELATIVE_QUATERNION_TO_EULER_ASSERT_SVH
`define RELATIVE_QUATERNION_TO_EULER_ASSERT_SVH
// implication checked on every clock, disabled in reset
`define RQE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define RQE_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/rqe_pkg.sv -----
// Package for the relative quaternion to Euler block: payload types,
// register indexes and the CORDIC angle table. No dependencies.
package rqe_pkg;
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll_deg;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] yaw_deg;
    } euler_t;

    localparam logic [2:0] REG_REF_W = 3'd0;
    localparam logic [2:0] REG_REF_X = 3'd1;
    localparam logic [2:0] REG_REF_Y = 3'd2;
    localparam logic [2:0] REG_REF_Z = 3'd3;
    localparam logic [2:0] REG_REF_EN = 3'd4;

    localparam int CORDIC_STEPS = 20;
    localparam int AW = 40;   // CORDIC vector / angle width
    localparam logic signed [AW-1:0] DEG180 = 40'sd11796480;
    localparam logic signed [17:0] OUT_LIMIT = 18'sd23040;

    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
            5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
            5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
            5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
            5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
            5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
            5'd12: r = 22'd917;     5'd13: r = 22'd458;
            5'd14: r = 22'd229;     5'd15: r = 22'd115;
            5'd16: r = 22'd57;      5'd17: r = 22'd29;
            5'd18: r = 22'd14;      5'd19: r = 22'd7;
            default: r = 22'd0;
        endcase
        return r;
    endfunction
endpackage

// ----- rtl/core/rqe_cordic.sv -----
// Iterative CORDIC vectoring unit: atan2 in 2^-16 degree, one step a cycle.
// Depends on rqe_pkg.
module rqe_cordic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [rqe_pkg::AW-1:0]  arg_y,
    input  logic signed [rqe_pkg::AW-1:0]  arg_x,
    output logic                           done,
    output logic signed [rqe_pkg::AW-1:0]  angle
);
    import rqe_pkg::*;

    logic signed [AW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0] step_reg, step_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic signed [AW-1:0] dx, dy, tab;

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign tab = AW'(signed'({1'b0, atan_tab(step_reg)}));

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = 5'd0;
            if (arg_x == '0 && arg_y == '0)
            begin
                x_next = '0;
                y_next = '0;
                z_next = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (arg_x < 0)
            begin
                x_next = -arg_x;
                y_next = -arg_y;
                z_next = (arg_y >= 0) ? DEG180 : -DEG180;
                busy_next = 1'b1;
            end
            else
            begin
                x_next = arg_x;
                y_next = arg_y;
                z_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + tab;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - tab;
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign angle = z_reg;
endmodule

// ----- rtl/core/relative_quaternion_to_euler.sv -----
// A decimated sample runs the relative quaternion products and rounding (reference on only),
// the argument products and three CORDIC runs, then raises out_valid; an atan2 with two zero
// arguments ends its run early. No new sample is accepted until out_valid is taken, so an output
// stall holds the input; samples skipped by the decimation are accepted while idle.
// Reset: asynchronous, active low; references to identity, phase to zero.
// Depends on rqe_pkg, rqe_cordic and the assertion header.
module relative_quaternion_to_euler #(
    parameter int DECIMATION = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rqe_pkg::quat_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output rqe_pkg::euler_t out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_wdata
);
    import rqe_pkg::*;
    `include "relative_quaternion_to_euler_assert.svh"

    localparam int PW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [3:0] S_IDLE = 4'd0, S_REL = 4'd1, S_RND = 4'd2,
        S_ARG = 4'd3, S_C0 = 4'd4, S_W0 = 4'd5, S_C1 = 4'd6, S_W1 = 4'd7,
        S_C2 = 4'd8, S_W2 = 4'd9, S_OUT = 4'd10;

    logic [3:0] st_reg, st_next;
    logic [PW-1:0] phase_reg;
    logic signed [15:0] rw_reg, rx_reg, ry_reg, rz_reg;
    logic ren_reg;
    logic signed [19:0] q_reg [4];
    logic signed [AW-1:0] acc_reg [5];
    logic signed [AW-1:0] acc_c;
    logic [4:0] k_reg;
    logic signed [19:0] ma, mb;
    logic signed [39:0] prod;
    logic neg;
    logic [2:0] dst;
    logic c_start, c_done;
    logic signed [AW-1:0] c_y, c_x, c_ang;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic ov_reg;
    logic signed [17:0] rn;
    logic signed [AW-1:0] rs;
    logic acc_in;

    assign in_stall = (st_reg != S_IDLE);
    assign acc_in = in_valid && !in_stall;

    // multiply schedule: product terms for the relative quaternion (k 0..15)
    // then the five angle arguments (k 16..25)
    always_comb
    begin
        ma = '0; mb = '0; neg = 1'b0; dst = 3'd0;
        if (st_reg == S_REL)
        begin
            dst = 3'(k_reg[3:2]);
            case (k_reg[1:0])
                2'd0: ma = 20'(rw_reg);
                2'd1: ma = 20'(rx_reg);
                2'd2: ma = 20'(ry_reg);
                default: ma = 20'(rz_reg);
            endcase
            // conj(ref)*q : component j = sum sign * ref_m * q_n
            case (k_reg[3:0])
                4'd0: begin mb = q_reg[0]; end
                4'd1: begin mb = q_reg[1]; end
                4'd2: begin mb = q_reg[2]; end
                4'd3: begin mb = q_reg[3]; end
                4'd4: begin mb = q_reg[1]; end
                4'd5: begin mb = q_reg[0]; neg = 1'b1; end
                4'd6: begin mb = q_reg[3]; neg = 1'b1; end
                4'd7: begin mb = q_reg[2]; end
                4'd8: begin mb = q_reg[2]; end
                4'd9: begin mb = q_reg[3]; end
                4'd10: begin mb = q_reg[0]; neg = 1'b1; end
                4'd11: begin mb = q_reg[1]; neg = 1'b1; end
                4'd12: begin mb = q_reg[3]; end
                4'd13: begin mb = q_reg[2]; neg = 1'b1; end
                4'd14: begin mb = q_reg[1]; end
                default: begin mb = q_reg[0]; neg = 1'b1; end
            endcase
        end
        else
        begin
            // sr=2(wx+yz) cr=1-2(xx+yy) syz=1-2(yy+zz) sp=2(wy+xz) sy=2(wz+xy)
            case (k_reg)
                5'd16: begin ma = q_reg[0]; mb = q_reg[1]; dst = 3'd0; end
                5'd17: begin ma = q_reg[2]; mb = q_reg[3]; dst = 3'd0; end
                5'd18: begin ma = q_reg[1]; mb = q_reg[1]; dst = 3'd1; neg = 1'b1; end
                5'd19: begin ma = q_reg[2]; mb = q_reg[2]; dst = 3'd1; neg = 1'b1; end
                5'd20: begin ma = q_reg[2]; mb = q_reg[2]; dst = 3'd2; neg = 1'b1; end
                5'd21: begin ma = q_reg[3]; mb = q_reg[3]; dst = 3'd2; neg = 1'b1; end
                5'd22: begin ma = q_reg[0]; mb = q_reg[2]; dst = 3'd3; end
                5'd23: begin ma = q_reg[1]; mb = q_reg[3]; dst = 3'd3; end
                5'd24: begin ma = q_reg[0]; mb = q_reg[3]; dst = 3'd4; end
                default: begin ma = q_reg[1]; mb = q_reg[2]; dst = 3'd4; end
            endcase
        end
    end

    assign prod = ma * mb;
    assign acc_c = neg ? (acc_reg[dst] - AW'(prod)) : (acc_reg[dst] + AW'(prod));

    always_comb
    begin
        st_next = st_reg;
        c_start = 1'b0;
        c_y = acc_reg[0];
        c_x = acc_reg[1];
        case (st_reg)
            S_IDLE:
                if (acc_in && phase_reg == PW'(DECIMATION - 1))
                    st_next = ren_reg ? S_REL : S_ARG;
            S_REL: if (k_reg == 5'd15) st_next = S_RND;
            S_RND: st_next = S_ARG;
            S_ARG:
                if (k_reg == 5'd25)
                    st_next = S_C0;
            S_C0: begin c_start = 1'b1; st_next = S_W0; end
            S_W0: if (c_done) st_next = S_C1;
            S_C1: begin c_start = 1'b1; c_y = acc_reg[3]; c_x = acc_reg[2];
                st_next = S_W1; end
            S_W1: if (c_done) st_next = S_C2;
            S_C2: begin c_start = 1'b1; c_y = acc_reg[4]; c_x = acc_reg[2];
                st_next = S_W2; end
            S_W2: if (c_done) st_next = S_OUT;
            S_OUT: if (!ov_reg) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    rqe_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .arg_y (c_y),
        .arg_x (c_x),
        .done  (c_done),
        .angle (c_ang)
    );

    // round to 1/128 degree, optionally negate, saturate
    assign rs = (c_ang + AW'(256)) >>> 9;
    always_comb
    begin
        logic signed [AW-1:0] v;
        v = (st_reg == S_W2) ? -rs : rs;
        if (v > AW'(OUT_LIMIT)) rn = OUT_LIMIT;
        else if (v < -AW'(OUT_LIMIT)) rn = -OUT_LIMIT;
        else rn = 18'(v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            phase_reg <= '0;
            rw_reg <= 16'sd16384;
            rx_reg <= '0;
            ry_reg <= '0;
            rz_reg <= '0;
            ren_reg <= 1'b0;
            ov_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REF_W: rw_reg <= cfg_wdata;
                    REG_REF_X: rx_reg <= cfg_wdata;
                    REG_REF_Y: ry_reg <= cfg_wdata;
                    REG_REF_Z: rz_reg <= cfg_wdata;
                    REG_REF_EN: ren_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (acc_in)
                phase_reg <= (phase_reg == PW'(DECIMATION - 1)) ? '0 : phase_reg + PW'(1);
            if (st_reg == S_IDLE)
                k_reg <= ren_reg ? 5'd0 : 5'd16;
            else if (st_reg == S_REL || st_reg == S_ARG)
                k_reg <= k_reg + 5'd1;
            if (st_reg == S_W2 && c_done)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            q_reg[0] <= 20'(in_data.quat_w);
            q_reg[1] <= 20'(in_data.quat_x);
            q_reg[2] <= 20'(in_data.quat_y);
            q_reg[3] <= 20'(in_data.quat_z);
            for (int i = 0; i < 5; i++)
                acc_reg[i] <= '0;
        end
        if (st_reg == S_REL)
            acc_reg[dst] <= acc_c;
        if (st_reg == S_RND)
        begin
            // relative quaternion, rounded and not saturated
            for (int i = 0; i < 4; i++)
            begin
                q_reg[i] <= 20'((acc_reg[i] + AW'(8192)) >>> 14);
                acc_reg[i] <= '0;
            end
        end
        if (st_reg == S_ARG)
        begin
            if (k_reg == 5'd16)
            begin
                acc_reg[0] <= AW'(prod);
                acc_reg[1] <= '0;
                acc_reg[2] <= '0;
                acc_reg[3] <= '0;
                acc_reg[4] <= '0;
            end
            else if (k_reg != 5'd25)
                acc_reg[dst] <= acc_c;
            if (k_reg == 5'd25)
            begin
                // double, then add one for the cosine-like terms
                acc_reg[0] <= acc_reg[0] <<< 1;
                acc_reg[1] <= (acc_reg[1] <<< 1) + (AW'(1) <<< 28);
                acc_reg[2] <= (acc_reg[2] <<< 1) + (AW'(1) <<< 28);
                acc_reg[3] <= acc_reg[3] <<< 1;
                acc_reg[4] <= (acc_c) <<< 1;
            end
        end
        if (st_reg == S_W0 && c_done) roll_reg <= 16'(rn);
        if (st_reg == S_W1 && c_done) pitch_reg <= 16'(rn);
        if (st_reg == S_W2 && c_done) yaw_reg <= 16'(rn);
    end

    assign out_valid = ov_reg;
    assign out_data.roll_deg = roll_reg;
    assign out_data.pitch_deg = pitch_reg;
    assign out_data.yaw_deg = yaw_reg;

    `RQE_ASSERT_IMP(a_busy_stalls, clk, rst_n, ov_reg, in_stall)
    `RQE_ASSERT_NXT(a_out_hold, clk, rst_n, ov_reg && out_stall, ov_reg && $stable(out_data))
    `RQE_ASSERT_IMP(a_start_idle, clk, rst_n, c_start, st_reg != S_IDLE)
endmodule
